@@ design/hrss_pkg.sv @@
package hrss_pkg;

    localparam int MAX_SOURCES_DEF = 8;
    localparam int ID_BITS_DEF     = 64;
    localparam int RTT_BITS_DEF    = 32;

    localparam logic [7:0] DEFAULT_THRESHOLD = 8'd3;
    localparam logic [7:0] DEFAULT_ALPHA     = 8'd4;
    localparam logic [15:0] RUN_MAX          = 16'hFFFF;
    localparam logic [31:0] TOTAL_MAX        = 32'hFFFF_FFFF;

    localparam logic [2:0] CMD_REGISTER = 3'd0;
    localparam logic [2:0] CMD_SUCCESS  = 3'd1;
    localparam logic [2:0] CMD_FAILURE  = 3'd2;
    localparam logic [2:0] CMD_PICK     = 3'd3;
    localparam logic [2:0] CMD_ENABLE   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_NONE    = 2'd3;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_ALPHA     = 1'b1;

    // command broadcast from the controller to every cell
    typedef struct packed {
        logic       clear;    // register new id in the addressed cell
        logic       success;
        logic       failure;
        logic       enable;
        logic [2:0] index;
        logic [7:0] threshold;
    } cell_cmd_t;

endpackage

@@ design/hrss_divider.sv @@
// restoring divider, one quotient bit per cycle
module hrss_divider #(
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [7:0]   divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg;
    logic [8:0]    rem_reg;
    logic [7:0]    dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [8:0]    trial;

    assign trial    = {rem_reg[7:0], quo_reg[W-1]};
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dvs_reg  <= divisor;
                cnt_reg  <= CW'(W);
            end else if (busy_reg) begin
                if (trial >= {1'b0, dvs_reg}) begin
                    rem_reg <= trial - {1'b0, dvs_reg};
                    quo_reg <= {quo_reg[W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
endmodule

@@ design/hrss_cell.sv @@
// one table slot; also one stage of the pick chain
module hrss_cell #(
    parameter int ID_BITS  = 64,
    parameter int RTT_BITS = 32,
    parameter logic [2:0] SLOT = 3'd0
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hrss_pkg::cell_cmd_t     cmd,
    input  logic [ID_BITS-1:0]      new_id,
    input  logic                    rtt_wr,
    input  logic [RTT_BITS-1:0]     rtt_value,
    input  logic [ID_BITS-1:0]      probe_id,
    output logic                    id_match,
    output logic [RTT_BITS-1:0]     rtt_out,
    // pick chain
    input  logic                    spread,
    input  logic [7:0]              load,
    input  logic                    used,
    input  logic                    in_have,
    input  logic [2:0]              in_best,
    input  logic [7:0]              in_load,
    input  logic [15:0]             in_run,
    input  logic [RTT_BITS-1:0]     in_rtt,
    input  logic [31:0]             in_total,
    output logic                    out_have,
    output logic [2:0]              out_best,
    output logic [7:0]              out_load,
    output logic [15:0]             out_run,
    output logic [RTT_BITS-1:0]     out_rtt,
    output logic [31:0]             out_total
);
    import hrss_pkg::*;

    logic [ID_BITS-1:0]  id_reg;
    logic                en_reg;
    logic [15:0]         run_reg;
    logic [31:0]         total_reg;
    logic [RTT_BITS-1:0] rtt_reg;
    logic [15:0]         run_next;
    logic                sel;
    logic                beats;
    logic [RTT_BITS-1:0] rank_rtt;

    assign id_match = used && (id_reg == probe_id);
    assign rtt_out  = rtt_reg;
    assign run_next = (run_reg != RUN_MAX) ? run_reg + 16'd1 : run_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0;
        end else if (cmd.index == SLOT) begin
            if (cmd.clear) begin
                id_reg    <= new_id;
                en_reg    <= 1'b1;
                run_reg   <= '0;
                total_reg <= '0;
                rtt_reg   <= '0;
            end
            if (cmd.success) begin
                en_reg  <= 1'b1;
                run_reg <= '0;
            end
            if (rtt_wr) rtt_reg <= rtt_value;
            if (cmd.failure) begin
                run_reg <= run_next;
                if (total_reg != TOTAL_MAX) total_reg <= total_reg + 32'd1;
                if ({8'd0, cmd.threshold} <= run_next) en_reg <= 1'b0;
            end
            if (cmd.enable) en_reg <= 1'b1;
        end
    end

    assign rank_rtt = (rtt_reg == '0) ? '1 : rtt_reg;

    always_comb begin
        if (run_reg != in_run)          beats = run_reg < in_run;
        else if (rank_rtt != in_rtt)    beats = rank_rtt < in_rtt;
        else                            beats = total_reg < in_total;
        if (!(used && en_reg))          sel = 1'b0;
        else if (!in_have)              sel = 1'b1;
        else if (spread)                sel = (load < in_load) || (load == in_load && beats);
        else                            sel = beats;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_have <= 1'b0;
        end else begin
            out_have <= in_have | sel;
        end
        out_best  <= sel ? SLOT : in_best;
        out_load  <= sel ? load : in_load;
        out_run   <= sel ? run_reg : in_run;
        out_rtt   <= sel ? rank_rtt : in_rtt;
        out_total <= sel ? total_reg : in_total;
    end
endmodule

@@ design/health_ranked_source_selector_top.sv @@
// health-ranked source selector
// input channel s_*: one command transaction (register, success, failure,
// pick, enable); result channel m_*: exactly one status transaction each
// configuration: cfg_we/cfg_index/cfg_data write the failure threshold (0)
// and the rtt divisor (1); zero acts as the default value
// a pick walks the ranking chain one cell per cycle; a success with a stored
// rtt waits for the bit-serial divider, which divides the rtt change by the
// rtt divisor
// one command in flight at a time; s_ready is high once the previous result
// has moved into the output register, so a new command is taken while the
// result still waits for m_ready
// reset (synchronous, aresetn low): empty table, defaults in the registers,
// no result pending
// a stalled receiver holds m_valid and the result; the block then takes at
// most one more command and finishes it into its working state
module health_ranked_source_selector_top #(
    parameter int MAX_SOURCES = hrss_pkg::MAX_SOURCES_DEF,
    parameter int ID_BITS     = hrss_pkg::ID_BITS_DEF,
    parameter int RTT_BITS    = hrss_pkg::RTT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_cmd,
    input  logic [63:0] s_source_id,
    input  logic [2:0]  s_source_index,
    input  logic [31:0] s_rtt_ms,
    input  logic        s_prefer_spread,
    input  logic [63:0] s_in_flight_packed,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_chosen_index
);
    import hrss_pkg::*;

    localparam int NW = MAX_SOURCES > 1 ? $clog2(MAX_SOURCES + 1) : 1;

    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_DIV, S_APPLY, S_PICK, S_DONE} state_t;

    state_t              state_reg;
    logic [7:0]          thr_reg, alpha_reg;
    logic [NW-1:0]       used_reg;
    logic [2:0]          cmd_reg, idx_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [RTT_BITS-1:0] rtt_in_reg;
    logic                spread_reg;
    logic [63:0]         load_reg;
    logic [1:0]          work_status_reg;
    logic [2:0]          work_index_reg;
    logic [1:0]          res_status_reg;
    logic [2:0]          res_index_reg;
    logic                res_valid_reg;
    logic [NW:0]         pick_cnt_reg;
    logic                up_reg;
    logic [RTT_BITS-1:0] s_cur_reg;
    cell_cmd_t           ccmd;
    logic                rtt_wr;
    logic [RTT_BITS-1:0] rtt_value;
    logic                div_start, div_done;
    logic [RTT_BITS-1:0] div_q;
    logic [RTT_BITS-1:0] diff;
    logic [MAX_SOURCES-1:0] match;
    logic [RTT_BITS-1:0] rtt_rd [MAX_SOURCES];
    logic                slot_ok;
    logic                reg_new;
    logic [1:0]          dec_status;

    logic                ch_have  [MAX_SOURCES+1];
    logic [2:0]          ch_best  [MAX_SOURCES+1];
    logic [7:0]          ch_load  [MAX_SOURCES+1];
    logic [15:0]         ch_run   [MAX_SOURCES+1];
    logic [RTT_BITS-1:0] ch_rtt   [MAX_SOURCES+1];
    logic [31:0]         ch_total [MAX_SOURCES+1];

    // chain head: nothing chosen yet
    assign ch_have[0]  = 1'b0;
    assign ch_best[0]  = '0;
    assign ch_load[0]  = '0;
    assign ch_run[0]   = '0;
    assign ch_rtt[0]   = '0;
    assign ch_total[0] = '0;

    assign slot_ok = {1'b0, idx_reg} < 4'(used_reg) && 32'(idx_reg) < MAX_SOURCES;

    // register of a nonzero id that is not yet in the table and still fits
    assign reg_new = cmd_reg == CMD_REGISTER && id_reg != '0 && match == '0
                     && 32'(used_reg) < MAX_SOURCES;

    genvar g;
    generate
        for (g = 0; g < MAX_SOURCES; g++) begin : g_cell
            hrss_cell #(
                .ID_BITS(ID_BITS), .RTT_BITS(RTT_BITS), .SLOT(3'(g))
            ) u_cell (
                .aclk, .aresetn,
                .cmd(ccmd), .new_id(id_reg), .rtt_wr(rtt_wr), .rtt_value(rtt_value),
                .probe_id(id_reg), .id_match(match[g]), .rtt_out(rtt_rd[g]),
                .spread(spread_reg), .load(load_reg[8*g +: 8]),
                .used(32'(used_reg) > g),
                .in_have(ch_have[g]), .in_best(ch_best[g]), .in_load(ch_load[g]),
                .in_run(ch_run[g]), .in_rtt(ch_rtt[g]), .in_total(ch_total[g]),
                .out_have(ch_have[g+1]), .out_best(ch_best[g+1]),
                .out_load(ch_load[g+1]), .out_run(ch_run[g+1]),
                .out_rtt(ch_rtt[g+1]), .out_total(ch_total[g+1])
            );
        end
    endgenerate

    hrss_divider #(.W(RTT_BITS)) u_div (
        .aclk, .aresetn, .start(div_start), .dividend(diff),
        .divisor(alpha_reg == 8'd0 ? DEFAULT_ALPHA : alpha_reg),
        .done(div_done), .quotient(div_q)
    );

    assign diff = up_reg ? rtt_in_reg - s_cur_reg : s_cur_reg - rtt_in_reg;

    // status of the command held in the decode stage
    always_comb begin
        case (cmd_reg)
            CMD_REGISTER: begin
                if (id_reg == '0)                                    dec_status = ST_INVALID;
                else if (match == '0 && 32'(used_reg) >= MAX_SOURCES) dec_status = ST_FULL;
                else                                                 dec_status = ST_OK;
            end
            CMD_SUCCESS, CMD_FAILURE, CMD_ENABLE:
                dec_status = slot_ok ? ST_OK : ST_INVALID;
            CMD_PICK: dec_status = ST_OK;
            default:  dec_status = ST_INVALID;
        endcase
    end

    // one-cycle pulses toward the cells
    always_comb begin
        ccmd.clear     = 1'b0;
        ccmd.success   = 1'b0;
        ccmd.failure   = 1'b0;
        ccmd.enable    = 1'b0;
        ccmd.index     = idx_reg;
        ccmd.threshold = thr_reg == 8'd0 ? DEFAULT_THRESHOLD : thr_reg;
        rtt_wr         = 1'b0;
        rtt_value      = up_reg ? s_cur_reg + div_q : s_cur_reg - div_q;
        div_start      = 1'b0;
        if (state_reg == S_DECODE && slot_ok) begin
            case (cmd_reg)
                CMD_FAILURE: ccmd.failure = 1'b1;
                CMD_ENABLE:  ccmd.enable  = 1'b1;
                CMD_SUCCESS: ccmd.success = 1'b1;
                default: ;
            endcase
        end
        if (state_reg == S_DECODE && reg_new) begin
            ccmd.clear = 1'b1;
            ccmd.index = 3'(used_reg);
        end
        if (state_reg == S_APPLY) begin
            div_start = s_cur_reg != '0;
            if (s_cur_reg == '0) begin
                rtt_wr    = 1'b1;
                rtt_value = rtt_in_reg;
            end
        end
        if (state_reg == S_DIV && div_done) rtt_wr = 1'b1;
    end

    assign s_ready = state_reg == S_IDLE && aresetn;
    assign m_valid = res_valid_reg;
    assign m_status = res_status_reg;
    assign m_chosen_index = res_index_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            thr_reg       <= DEFAULT_THRESHOLD;
            alpha_reg     <= DEFAULT_ALPHA;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
            pick_cnt_reg  <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_THRESHOLD) thr_reg <= cfg_data;
                else                            alpha_reg <= cfg_data;
            end
            // output register drains unless it is refilled in the same cycle
            if (m_valid && m_ready && state_reg != S_DONE) res_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (s_valid) begin
                    cmd_reg    <= s_cmd;
                    id_reg     <= s_source_id[ID_BITS-1:0];
                    idx_reg    <= s_source_index;
                    rtt_in_reg <= RTT_BITS'(s_rtt_ms);
                    spread_reg <= s_prefer_spread;
                    load_reg   <= s_in_flight_packed;
                    state_reg  <= S_DECODE;
                end
                S_DECODE: begin
                    work_status_reg <= dec_status;
                    work_index_reg  <= '0;
                    case (cmd_reg)
                        CMD_REGISTER: begin
                            if (reg_new) used_reg <= used_reg + 1'b1;
                            state_reg <= S_DONE;
                        end
                        CMD_SUCCESS: begin
                            if (slot_ok) begin
                                s_cur_reg <= rtt_rd[idx_reg[$clog2(MAX_SOURCES)-1:0]];
                                up_reg    <= rtt_in_reg >=
                                             rtt_rd[idx_reg[$clog2(MAX_SOURCES)-1:0]];
                                state_reg <= S_APPLY;
                            end else begin
                                state_reg <= S_DONE;
                            end
                        end
                        CMD_PICK: begin
                            pick_cnt_reg <= '0;
                            state_reg    <= S_PICK;
                        end
                        default: state_reg <= S_DONE;
                    endcase
                end
                S_APPLY: state_reg <= (s_cur_reg == '0) ? S_DONE : S_DIV;
                S_DIV:   if (div_done) state_reg <= S_DONE;
                S_PICK: begin
                    pick_cnt_reg <= pick_cnt_reg + 1'b1;
                    if (32'(pick_cnt_reg) == MAX_SOURCES) begin
                        if (ch_have[MAX_SOURCES]) work_index_reg <= ch_best[MAX_SOURCES];
                        else work_status_reg <= ST_NONE;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE: if (!res_valid_reg || m_ready) begin
                    res_valid_reg  <= 1'b1;
                    res_status_reg <= work_status_reg;
                    res_index_reg  <= work_index_reg;
                    state_reg      <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
